[design/udpffc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP fragment frame checker package
// Field widths, saturation limits and the input and result word types.
// ----------------------------------------------------------------------------
package udpffc_pkg;

  // Field widths of the header word and the result word.
  localparam int ID_W   = 32;
  localparam int SIZE_W = 24;
  localparam int IDX_W  = 8;
  localparam int LEN_W  = 11;
  localparam int OFS_W  = 20;
  localparam int CNT_W  = 9;

  // Longest payload kept; longer datagrams count as cut to this size.
  localparam int MAX_PAYLOAD = 2040;

  // Saturation limits of the byte offset and the fragment counter.
  localparam logic [OFS_W-1:0] OFFSET_MAX = {OFS_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};

  // Fraction bits of the reciprocal used to divide the frame size.
  localparam int RECIP_SHIFT = SIZE_W;

  // One received datagram header.
  typedef struct packed {
    logic [ID_W-1:0]   frame_id;
    logic [SIZE_W-1:0] frame_size;
    logic [IDX_W-1:0]  fragment_index;
    logic [LEN_W-1:0]  payload_length;
  } in_word_t;

  // One check result.
  typedef struct packed {
    logic [ID_W-1:0]  frame_tag;
    logic [OFS_W-1:0] write_offset;
    logic             fragment_broken;
    logic             frame_end;
    logic             frame_good;
    logic [OFS_W-1:0] frame_length;
  } out_word_t;

endpackage

[design/udp_fragment_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP fragment frame checker
// Checks each datagram header against the frame being gathered and reports
// the payload offset, broken and end-of-frame flags and the gathered length.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Word
//  --------+-----------+---------------------------+-----------
//  in      | input     | in_valid_i / in_stall_o   | in_word_t
//  out     | output    | out_valid_o / out_stall_i | out_word_t
//
// One word is taken per cycle while in_stall_o is low; each result passes
// through three pipeline registers behind the input register, then the
// result register.
// The frame size is divided by a reciprocal multiply, a back multiply and a
// single correction step, each behind its own register; the counter and the
// offset are read and written only in the last stage, so words may follow
// each other in consecutive cycles.
// Reset clears the stage valid bits, the fragment counter and the offset.
// A stalled result holds; earlier stages keep filling until they are full.
// ----------------------------------------------------------------------------
module udp_fragment_frame_checker
  import udpffc_pkg::*;
#(
  parameter int FRAGMENT_BYTES = 1464
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  // Divider constants worked out at elaboration.
  localparam int RecipInt = (1 << RECIP_SHIFT) / FRAGMENT_BYTES;
  localparam int MulW     = $clog2(RecipInt + 1);
  localparam int QuotW    = $clog2(((1 << SIZE_W) - 1) / FRAGMENT_BYTES + 1);
  localparam int DivW     = $clog2(FRAGMENT_BYTES + 1);
  localparam int RemW     = (FRAGMENT_BYTES > 2) ? $clog2(FRAGMENT_BYTES) : 1;
  localparam int MaxLen   = (MAX_PAYLOAD > (1 << LEN_W) - 1) ? (1 << LEN_W) - 1
                                                               : MAX_PAYLOAD;

  localparam logic [MulW-1:0]   Recip  = MulW'(RecipInt);
  localparam logic [DivW-1:0]   FragC  = DivW'(FRAGMENT_BYTES);
  localparam logic [LEN_W-1:0]  MaxLenC = LEN_W'(MaxLen);

  // Pipeline registers.
  logic                  v1_q, v2_q, v3_q, v4_q, vo_q;
  in_word_t              s1_q, s2_q, s3_q, s4_q;
  logic [QuotW-1:0]      s2_quot_q, s3_quot_q, s4_full_q;
  logic [SIZE_W-1:0]     s3_prod_q;
  logic [RemW-1:0]       s4_rem_q;
  out_word_t             out_q;

  // Frame state.
  logic [CNT_W-1:0]      count_q, count_d;
  logic [OFS_W-1:0]      offset_q, offset_d;

  // Stage ready chain: a stage moves on when it is empty or the next moves.
  logic                  rdy_o, rdy4, rdy3, rdy2, rdy1;

  assign rdy_o = !vo_q || !out_stall_i;
  assign rdy4  = !v4_q || rdy_o;
  assign rdy3  = !v3_q || rdy4;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  // Stage 2 math: clamp the length and estimate the quotient.
  logic [SIZE_W+MulW-1:0] recip_prod;
  in_word_t               s2_word;

  assign recip_prod = SIZE_W'(s1_q.frame_size) * Recip;

  always_comb begin
    s2_word = s1_q;
    if (s1_q.payload_length > MaxLenC) begin
      s2_word.payload_length = MaxLenC;
    end
  end

  // Stage 3 math: multiply the estimate back by the fragment size.
  logic [QuotW+DivW-1:0] back_prod;

  assign back_prod = s2_quot_q * FragC;

  // Stage 4 math: one correction step gives the full count and remainder.
  logic [SIZE_W-1:0] rem_est;
  logic              rem_over;

  assign rem_est  = s3_q.frame_size - s3_prod_q;
  assign rem_over = rem_est >= SIZE_W'(FragC);

  // Final stage: checks against the counter and the offset.
  logic              idx_low, len_bad, idx_bad, broken, frame_end;
  logic [OFS_W:0]    total_sum;
  logic [OFS_W-1:0]  total;
  logic              fire4;

  assign fire4 = v4_q && rdy_o;

  always_comb begin
    idx_low = 32'(s4_q.fragment_index) < 32'(s4_full_q);
    if (idx_low) begin
      len_bad = 32'(s4_q.payload_length) != 32'(FragC);
    end else begin
      len_bad = 32'(s4_q.payload_length) != 32'(s4_rem_q);
    end
    idx_bad   = 32'(s4_q.fragment_index) != 32'(count_q);
    broken    = len_bad || idx_bad;
    frame_end = broken || (32'(count_q) >= 32'(s4_full_q)) ||
                ((s4_rem_q == '0) && (s4_full_q != '0) &&
                 (32'(count_q) + 32'd1 == 32'(s4_full_q)));

    total_sum = {1'b0, offset_q} + (OFS_W + 1)'(s4_q.payload_length);
    total     = total_sum[OFS_W] ? OFFSET_MAX : total_sum[OFS_W-1:0];

    count_d  = count_q;
    offset_d = offset_q;
    if (fire4) begin
      if (frame_end) begin
        count_d  = '0;
        offset_d = '0;
      end else begin
        if (count_q != COUNT_MAX) begin
          count_d = count_q + CNT_W'(1);
        end
        offset_d = total;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      vo_q     <= 1'b0;
      count_q  <= '0;
      offset_q <= '0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy_o) vo_q <= v4_q;
      count_q  <= count_d;
      offset_q <= offset_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_q <= in_data_i;
    end
    if (rdy2 && v1_q) begin
      s2_q      <= s2_word;
      s2_quot_q <= recip_prod[RECIP_SHIFT +: QuotW];
    end
    if (rdy3 && v2_q) begin
      s3_q      <= s2_q;
      s3_quot_q <= s2_quot_q;
      s3_prod_q <= SIZE_W'(back_prod);
    end
    if (rdy4 && v3_q) begin
      s4_q <= s3_q;
      if (rem_over) begin
        s4_full_q <= s3_quot_q + QuotW'(1);
        s4_rem_q  <= RemW'(rem_est - SIZE_W'(FragC));
      end else begin
        s4_full_q <= s3_quot_q;
        s4_rem_q  <= RemW'(rem_est);
      end
    end
    if (fire4) begin
      out_q.frame_tag       <= s4_q.frame_id;
      out_q.write_offset    <= offset_q;
      out_q.fragment_broken <= broken;
      out_q.frame_end       <= frame_end;
      out_q.frame_good      <= frame_end && !broken;
      out_q.frame_length    <= total;
    end
  end

  // A good frame is always a closed frame with no broken fragment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_good |->
      out_data_o.frame_end && !out_data_o.fragment_broken)
    else $error("frame_good without a clean frame end");

  // Closing a frame clears the counter and the offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire4 && frame_end |=> (count_q == '0) && (offset_q == '0))
    else $error("frame state not cleared after frame end");

  // A word that does not close the frame moves the offset to the gathered length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire4 && !frame_end |=> offset_q == $past(total))
    else $error("byte offset did not advance");

  // The input is only held back by a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the result side is free");

endmodule

[bench/tb_udp_fragment_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the UDP fragment frame checker
// Sends datagram headers through the valid/stall input channel and checks
// every result word against a cycle-free model of the fragment counter and
// byte offset. Directed headers cover empty, exact-multiple and remainder
// frames, out-of-sequence indexes, wrong lengths and cut payloads. Random
// traffic is mostly well-formed frames, some broken midway and some noise.
// Both channels idle at random in three phases, the last one without gaps.
// ----------------------------------------------------------------------------
module tb_udp_fragment_frame_checker;
  import udpffc_pkg::*;

  localparam int unsigned FRAGMENT_BYTES = 1464;
  localparam int          CLK_PERIOD     = 8;
  localparam int          QUIET_LIMIT    = 2000;
  localparam int          LATENCY_TAIL   = 10;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_data_o;

  // Headers waiting to be sent and results predicted but not yet seen.
  in_word_t  pending_hdrs[$];
  out_word_t verdict_q[$];

  // Model state: fragments accepted so far and bytes gathered in the frame.
  logic [CNT_W-1:0] frag_count  = '0;
  logic [OFS_W-1:0] fill_offset = '0;

  int unsigned n_pushed       = 0;
  int unsigned n_taken        = 0;
  int          error_count    = 0;
  int          quiet_cycles   = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hdr_taken      = 1'b0;

  udp_fragment_frame_checker #(
    .FRAGMENT_BYTES(FRAGMENT_BYTES)
  ) uut (.*);

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Grades one header against the frame in progress and advances the state.
  function automatic out_word_t grade_fragment(in_word_t hdr);
    out_word_t   v;
    int unsigned len;
    int unsigned full;
    int unsigned rem;
    int unsigned total;
    logic        broken;
    logic        closes;
    len = hdr.payload_length;
    if (len > MAX_PAYLOAD) len = MAX_PAYLOAD;
    full = hdr.frame_size / FRAGMENT_BYTES;
    rem  = hdr.frame_size - full * FRAGMENT_BYTES;
    // Full fragments carry exactly FRAGMENT_BYTES; anything past them the remainder.
    if (hdr.fragment_index < full) broken = (len != FRAGMENT_BYTES);
    else broken = (len != rem);
    if (hdr.fragment_index != frag_count) broken = 1'b1;
    closes = broken || (frag_count >= full) ||
             (rem == 0 && full != 0 && frag_count == full - 1);
    total = fill_offset + len;
    if (total > OFFSET_MAX) total = OFFSET_MAX;
    v.frame_tag       = hdr.frame_id;
    v.write_offset    = fill_offset;
    v.fragment_broken = broken;
    v.frame_end       = closes;
    v.frame_good      = closes && !broken;
    v.frame_length    = OFS_W'(total);
    if (closes) begin
      frag_count  = '0;
      fill_offset = '0;
    end else begin
      if (frag_count != COUNT_MAX) frag_count = frag_count + CNT_W'(1);
      fill_offset = OFS_W'(total);
    end
    return v;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  task automatic push_header(logic [31:0] id, int unsigned size, int unsigned idx,
                             int unsigned len);
    in_word_t hdr;
    hdr.frame_id       = id;
    hdr.frame_size     = SIZE_W'(size);
    hdr.fragment_index = IDX_W'(idx);
    hdr.payload_length = LEN_W'(len);
    pending_hdrs.push_back(hdr);
    n_pushed++;
  endtask

  // Sends a frame in order; at position cut one word gets a bad index or length
  // and the frame stops there. A negative cut sends the whole frame.
  task automatic build_frame(int unsigned size, int cut);
    int unsigned full;
    int unsigned rem;
    int unsigned count;
    int unsigned want_len;
    logic [31:0] id;
    id    = $urandom();
    full  = size / FRAGMENT_BYTES;
    rem   = size - full * FRAGMENT_BYTES;
    count = full + ((rem != 0) ? 1 : 0);
    if (count == 0) count = 1;
    for (int pos = 0; pos < count; pos++) begin
      want_len = (pos < full) ? FRAGMENT_BYTES : rem;
      if (pos == cut) begin
        if ($urandom_range(0, 1) == 1)
          push_header(id, size, (pos + 1 + $urandom_range(0, 254)) % 256, want_len);
        else
          push_header(id, size, pos % 256, (want_len + 1 + $urandom_range(0, 2046)) % 2048);
        break;
      end
      push_header(id, size, pos % 256, want_len);
    end
  endtask

  // Mostly well-formed frames, some broken midway, the rest random noise.
  task automatic random_traffic(int unsigned items);
    int unsigned stop;
    int unsigned roll;
    int unsigned size;
    int unsigned n;
    stop = n_pushed + items;
    while (n_pushed < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2: size = $urandom_range(0, FRAGMENT_BYTES - 1);
        3, 4, 5: size = $urandom_range(FRAGMENT_BYTES, 8 * FRAGMENT_BYTES);
        6, 7:    size = $urandom_range(1, 6) * FRAGMENT_BYTES;
        default: size = $urandom_range(0, 24'hFFFFFF);
      endcase
      n = size / FRAGMENT_BYTES + ((size % FRAGMENT_BYTES != 0) ? 1 : 0);
      if (n == 0) n = 1;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        build_frame(size, (n > 8) ? int'($urandom_range(0, 7)) : -1);
      end else if (roll < 85) begin
        build_frame(size, $urandom_range(0, ((n > 8) ? 8 : n) - 1));
      end else begin
        repeat ($urandom_range(1, 3))
          push_header($urandom(), $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 255),
                      $urandom_range(0, 2047));
        // An index of 255 breaks whatever frame the noise left open.
        push_header($urandom(), size, 255, $urandom_range(0, 2047));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (n_taken != n_pushed || verdict_q.size() != 0);
  endtask

  // Input driver: holds a stalled word, otherwise sends the next one or idles.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || hdr_taken)) begin
      if (pending_hdrs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data_i  <= pending_hdrs.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver stalls at random.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Monitor: checks accepted results and predicts accepted headers.
  always @(posedge clk_i) begin : observe
    out_word_t want;
    bit        res_taken;
    hdr_taken = rst_ni && in_valid_i && !in_stall_o;
    res_taken = rst_ni && out_valid_o && !out_stall_i;
    if (res_taken) begin
      if (verdict_q.size() == 0) begin
        $error("frame_tag: expected no result, got 0x%0h", out_data_o.frame_tag);
        error_count++;
      end else begin
        want = verdict_q.pop_front();
        compare_field("frame_tag", want.frame_tag, out_data_o.frame_tag);
        compare_field("write_offset", want.write_offset, out_data_o.write_offset);
        compare_field("fragment_broken", want.fragment_broken, out_data_o.fragment_broken);
        compare_field("frame_end", want.frame_end, out_data_o.frame_end);
        compare_field("frame_good", want.frame_good, out_data_o.frame_good);
        compare_field("frame_length", want.frame_length, out_data_o.frame_length);
      end
    end
    if (hdr_taken) begin
      verdict_q.push_back(grade_fragment(in_data_i));
      n_taken++;
    end
    if (hdr_taken || res_taken) quiet_cycles = 0;
    else quiet_cycles++;
  end

  // Watchdog on cycles without any accepted word.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("** udp_fragment_frame_checker: FAILED **");
    $finish;
  end

  initial begin
    send_idle_pct  = 14;
    recv_stall_pct = 86;

    // Directed headers: empty frames, single and multi fragment frames,
    // exact multiples, wrong indexes and lengths, cut payloads, extremes.
    push_header(32'h0, 0, 0, 0);
    push_header(32'h1, 0, 0, 5);
    push_header(32'hFFFF_FFFF, 100, 0, 100);
    push_header(32'h2, FRAGMENT_BYTES, 0, FRAGMENT_BYTES);
    push_header(32'h3, FRAGMENT_BYTES, 0, 0);
    push_header(32'h4, 3000, 0, FRAGMENT_BYTES);
    push_header(32'h4, 3000, 1, FRAGMENT_BYTES);
    push_header(32'h4, 3000, 2, 3000 - 2 * FRAGMENT_BYTES);
    push_header(32'h5, 2 * FRAGMENT_BYTES, 0, FRAGMENT_BYTES);
    push_header(32'h5, 2 * FRAGMENT_BYTES, 1, FRAGMENT_BYTES);
    push_header(32'h6, 3000, 1, FRAGMENT_BYTES);
    push_header(32'h7, 5000, 0, FRAGMENT_BYTES);
    push_header(32'h7, 5000, 1, 2047);
    push_header(32'h8, 24'hFFFFFF, 0, 2047);
    push_header(32'h9, 24'hFFFFFF, 0, FRAGMENT_BYTES);
    push_header(32'h9, 24'hFFFFFF, 1, FRAGMENT_BYTES);
    push_header(32'h9, 24'hFFFFFF, 5, FRAGMENT_BYTES);
    push_header(32'hA, FRAGMENT_BYTES - 1, 255, FRAGMENT_BYTES - 1);
    push_header(32'hB, FRAGMENT_BYTES - 1, 0, FRAGMENT_BYTES - 1);
    push_header(32'hC, FRAGMENT_BYTES + 1, 0, FRAGMENT_BYTES);
    push_header(32'hC, FRAGMENT_BYTES + 1, 1, 1);
    push_header(32'hD, 3 * FRAGMENT_BYTES, 0, FRAGMENT_BYTES);
    push_header(32'hD, 3 * FRAGMENT_BYTES, 1, FRAGMENT_BYTES);
    push_header(32'hD, 3 * FRAGMENT_BYTES, 1, FRAGMENT_BYTES);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The sender holds off here until every directed result is back.
    wait_drained();
    random_traffic(55);
    wait_drained();

    @(posedge clk_i);
    send_idle_pct  = 86;
    recv_stall_pct = 14;
    random_traffic(55);
    wait_drained();

    // No gaps; one long frame runs the counter to the end of the index range.
    @(posedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    build_frame(300 * FRAGMENT_BYTES + $urandom_range(1, FRAGMENT_BYTES - 1), 256);
    random_traffic(55);
    wait_drained();

    repeat (LATENCY_TAIL) @(posedge clk_i);
    if (error_count == 0 && verdict_q.size() == 0)
      $display("** udp_fragment_frame_checker: PASSED **");
    else
      $display("** udp_fragment_frame_checker: FAILED **");
    $finish;
  end

endmodule

[udp_fragment_frame_checker.f]
design/udpffc_pkg.sv
design/udp_fragment_frame_checker.sv
bench/tb_udp_fragment_frame_checker.sv
